### rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SFD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SFD_ASSERT(lbl, prop, msg)
`define SFD_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/sfd_pkg.sv
package sfd_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int MIN_FRAME    = HEADER_BYTES + 2;
	localparam int PLEN_W       = 6;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_SYNC  = 3'd2,
		ST_CRC   = 3'd3,
		ST_LONG  = 3'd4
	} status_t;

	typedef enum logic {
		CFG_SYNC_FIRST  = 1'b0,
		CFG_SYNC_SECOND = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		PH_PAY  = 1'b0,
		PH_STAT = 1'b1
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} sfd_in_t;

	typedef struct packed {
		logic              out_kind;
		logic              out_last;
		logic [7:0]        out_byte;
		logic [2:0]        frame_status;
		logic [7:0]        node_id;
		logic [7:0]        sensor_type;
		logic [63:0]       timestamp;
		logic [PLEN_W-1:0] payload_len;
	} sfd_res_t;

	// one queue entry: an optional payload byte followed by an optional status
	typedef struct packed {
		logic              pay_vld;
		logic [7:0]        pay_byte;
		logic              stat_vld;
		status_t           status;
		logic [7:0]        node;
		logic [7:0]        stype;
		logic [63:0]       ts;
		logic [PLEN_W-1:0] plen;
	} sfd_job_t;

	// crc-16/ccitt-false over one byte, msb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/sfd_front.sv
module sfd_front #(
	parameter int MAX_FRAME = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  sfd_pkg::cfg_idx_t wr_index,
	input  logic [7:0]        wr_data,
	input  logic              accept,
	input  sfd_pkg::sfd_in_t  item,
	output logic              job_push,
	output sfd_pkg::sfd_job_t job
);
	import sfd_pkg::*;

	localparam int PW = $clog2(MAX_FRAME + 1);

	logic [7:0]  sync_first_q, sync_second_q;
	logic [PW-1:0] pos_q, pos_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  dly0_q, dly1_q, dly0_n, dly1_n;
	logic        sync_ok_q, sync_ok_n;
	logic [7:0]  node_q, node_n, stype_q, stype_n;
	logic [63:0] ts_q, ts_n;
	logic        ovf_q, ovf_n;
	logic [2:0]  lane;
	logic        pay_vld;
	status_t     status;
	logic [PLEN_W-1:0] plen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SYNC_FIRST:  sync_first_q  <= wr_data;
				CFG_SYNC_SECOND: sync_second_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign lane = pos_q[2:0] - 3'd4;

	always_comb begin
		pos_n     = pos_q;
		crc_n     = crc_q;
		dly0_n    = dly0_q;
		dly1_n    = dly1_q;
		sync_ok_n = sync_ok_q;
		node_n    = node_q;
		stype_n   = stype_q;
		ts_n      = ts_q;
		ovf_n     = ovf_q;
		pay_vld   = 1'b0;
		if (pos_q >= PW'(MAX_FRAME)) begin
			ovf_n = 1'b1;
		end else begin
			if (pos_q >= PW'(2)) begin
				crc_n = crc16_byte(crc_q, dly0_q);
			end
			// the byte leaving the delay line is payload once past the header
			pay_vld = (pos_q >= PW'(MIN_FRAME));
			dly0_n  = dly1_q;
			dly1_n  = item.in_byte;
			if (pos_q == PW'(0)) begin
				sync_ok_n = sync_ok_q && (item.in_byte == sync_first_q);
			end else if (pos_q == PW'(1)) begin
				sync_ok_n = sync_ok_q && (item.in_byte == sync_second_q);
			end else if (pos_q == PW'(2)) begin
				node_n = item.in_byte;
			end else if (pos_q == PW'(3)) begin
				stype_n = item.in_byte;
			end else if (pos_q < PW'(HEADER_BYTES)) begin
				ts_n[{lane, 3'b000} +: 8] = item.in_byte;
			end
			pos_n = pos_q + PW'(1);
		end
	end

	always_comb begin
		plen = '0;
		if (pos_n < PW'(MIN_FRAME)) begin
			status = ST_SHORT;
		end else if (ovf_n) begin
			status = ST_LONG;
		end else begin
			plen = PLEN_W'(pos_n - PW'(MIN_FRAME));
			if (!sync_ok_n) begin
				status = ST_SYNC;
			end else if ({dly1_n, dly0_n} != crc_n) begin
				status = ST_CRC;
			end else begin
				status = ST_OK;
			end
		end
	end

	always_comb begin
		job.pay_vld  = pay_vld;
		job.pay_byte = pay_vld ? dly0_q : 8'h00;
		job.stat_vld = item.in_last;
		job.status   = status;
		job.node     = node_n;
		job.stype    = stype_n;
		job.ts       = ts_n;
		job.plen     = plen;
		job_push     = accept && (pay_vld || item.in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			dly0_q    <= '0;
			dly1_q    <= '0;
			sync_ok_q <= 1'b1;
			node_q    <= '0;
			stype_q   <= '0;
			ts_q      <= '0;
			ovf_q     <= 1'b0;
		end else if (accept) begin
			if (item.in_last) begin
				pos_q     <= '0;
				crc_q     <= CRC_INIT;
				dly0_q    <= '0;
				dly1_q    <= '0;
				sync_ok_q <= 1'b1;
				node_q    <= '0;
				stype_q   <= '0;
				ts_q      <= '0;
				ovf_q     <= 1'b0;
			end else begin
				pos_q     <= pos_n;
				crc_q     <= crc_n;
				dly0_q    <= dly0_n;
				dly1_q    <= dly1_n;
				sync_ok_q <= sync_ok_n;
				node_q    <= node_n;
				stype_q   <= stype_n;
				ts_q      <= ts_n;
				ovf_q     <= ovf_n;
			end
		end
	end

endmodule

### rtl/sfd_queue.sv
`include "assert_macros.svh"

module sfd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  sfd_pkg::sfd_job_t wr_job,
	output logic              full,
	input  logic              rd_en,
	output sfd_pkg::sfd_job_t rd_job,
	output logic              empty
);
	import sfd_pkg::*;

	sfd_job_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	`SFD_NEVER(a_cnt_bound, cnt_q > QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
	`SFD_ASSERT(a_no_overrun, wr_en |-> (cnt_q != QCNT_W'(QUEUE_DEPTH)), "write into full queue")
	`SFD_ASSERT(a_no_underrun, rd_en |-> (cnt_q != '0), "read from empty queue")

endmodule

### rtl/sfd_back.sv
`include "assert_macros.svh"

module sfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sfd_pkg::sfd_job_t q_job,
	input  logic              q_empty,
	output logic              q_rd,
	output logic              empty,
	input  logic              pop,
	output sfd_pkg::sfd_res_t result
);
	import sfd_pkg::*;

	sfd_job_t job_q;
	logic     job_vld_q, job_vld_n;
	phase_t   phase_q, phase_n;
	logic     xfer, done;

	assign empty = !job_vld_q;
	assign xfer  = pop && job_vld_q;
	// a transfer in the payload phase finishes the entry unless a status follows
	assign done  = xfer && !(phase_q == PH_PAY && job_q.stat_vld);
	assign q_rd  = (!job_vld_q || done) && !q_empty;

	always_comb begin
		job_vld_n = job_vld_q;
		phase_n   = phase_q;
		if (q_rd) begin
			job_vld_n = 1'b1;
			phase_n   = q_job.pay_vld ? PH_PAY : PH_STAT;
		end else if (done) begin
			job_vld_n = 1'b0;
		end else if (xfer) begin
			phase_n = PH_STAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			phase_q   <= PH_PAY;
		end else begin
			job_vld_q <= job_vld_n;
			phase_q   <= phase_n;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			job_q <= q_job;
		end
	end

	always_comb begin
		result = '0;
		if (phase_q == PH_STAT) begin
			result.out_kind     = 1'b1;
			result.out_last     = 1'b1;
			result.frame_status = job_q.status;
			result.node_id      = job_q.node;
			result.sensor_type  = job_q.stype;
			result.timestamp    = job_q.ts;
			result.payload_len  = job_q.plen;
		end else begin
			result.out_last = !job_q.stat_vld;
			result.out_byte = job_q.pay_byte;
		end
	end

	`SFD_ASSERT(a_job_nonempty, job_vld_q |-> (job_q.pay_vld || job_q.stat_vld), "empty entry held")
	`SFD_ASSERT(a_stat_phase, (job_vld_q && phase_q == PH_STAT) |-> job_q.stat_vld, "status phase without status")
	`SFD_ASSERT(a_pay_then_stat, (xfer && phase_q == PH_PAY && job_q.stat_vld) |=> (job_vld_q && phase_q == PH_STAT), "status lost after payload")

endmodule

### rtl/sensor_frame_decoder.sv
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------
// bytes in  | push / full        | item   (in_byte, in_last)
// results   | empty / pop        | result (kind, last, byte, status, header)
// config    | wr_en              | wr_index, wr_data (sync bytes)
//
// one byte taken per cycle unless the queue is full; crc of the leaving byte
// and the status checks settle in the front stage in that cycle
// a byte that releases a payload byte and ends the frame gives two results,
// payload byte then status; a four-entry queue between front and back absorbs
// this; each result is held in a queue slot, then in the back entry register
// arst_n clears frame state and the queue and loads the sync bytes 0xaa / 0x55
// full rises only when the queue is full, so back-pressure on pop stalls push
module sensor_frame_decoder #(
	parameter int MAX_FRAME = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  sfd_pkg::sfd_in_t  item,
	output logic              empty,
	input  logic              pop,
	output sfd_pkg::sfd_res_t result,
	input  logic              wr_en,
	input  sfd_pkg::cfg_idx_t wr_index,
	input  logic [7:0]        wr_data
);
	import sfd_pkg::*;

	logic     accept;
	logic     job_push;
	sfd_job_t job_in, job_out;
	logic     q_empty, q_rd;

	assign accept = push && !full;

	sfd_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.accept  (accept),
		.item    (item),
		.job_push(job_push),
		.job     (job_in)
	);

	sfd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (job_push),
		.wr_job(job_in),
		.full  (full),
		.rd_en (q_rd),
		.rd_job(job_out),
		.empty (q_empty)
	);

	sfd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_job  (job_out),
		.q_empty(q_empty),
		.q_rd   (q_rd),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

### dv/tb_sensor_frame_decoder.sv
`timescale 1ns / 1ps

module tb_sensor_frame_decoder;
	import sfd_pkg::*;

	localparam int FRAME_MAX       = 64;
	localparam int DRAIN_CYCLES    = 6;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int BYTES_PER_PHASE = 255;

	typedef enum int {
		FR_GOOD,
		FR_BAD_SYNC,
		FR_BAD_CRC,
		FR_SHORT,
		FR_LONG,
		FR_NOISE
	} frame_kind_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	sfd_in_t   item = '0;
	logic      empty;
	logic      pop = 1'b0;
	sfd_res_t  result;
	logic      wr_en = 1'b0;
	cfg_idx_t  wr_index = CFG_SYNC_FIRST;
	logic [7:0] wr_data = '0;

	sensor_frame_decoder #(.MAX_FRAME(FRAME_MAX)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// decoder state as the frame checker sees it
	logic [7:0]  sync_a = SYNC_FIRST_RST;
	logic [7:0]  sync_b = SYNC_SECOND_RST;
	int unsigned frame_pos = 0;
	logic [15:0] crc_acc = CRC_INIT;
	logic [7:0]  dly [2] = '{8'h00, 8'h00};
	logic        sync_match = 1'b1;
	logic [7:0]  cap_node = '0;
	logic [7:0]  cap_type = '0;
	logic [63:0] cap_time = '0;
	logic        frame_overrun = 1'b0;

	sfd_res_t    frame_results_due [$];
	sfd_in_t     bytes_to_send [$];
	int unsigned bytes_sent = 0;
	int unsigned bytes_taken = 0;
	bit          in_taken = 1'b0;
	bit          res_taken = 1'b0;
	bit          failed = 1'b0;
	int unsigned idle_cycles = 0;

	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	int unsigned send_run = 0;
	int unsigned recv_run = 0;
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// msb-first shift register form of the ccitt polynomial
	function automatic logic [15:0] crc_after_byte(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0};
			if (fb) begin
				crc = crc ^ 16'h1021;
			end
		end
		return crc;
	endfunction

	// stretches with no idling are mixed at random with stretches of random waits
	function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit calm);
		if (run_left == 0) begin
			calm = ($urandom_range(0, 3) == 0);
			run_left = $urandom_range(10, 60);
		end
		run_left--;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	task automatic clear_frame_state();
		frame_pos = 0;
		crc_acc = CRC_INIT;
		dly[0] = 8'h00;
		dly[1] = 8'h00;
		sync_match = 1'b1;
		cap_node = '0;
		cap_type = '0;
		cap_time = '0;
		frame_overrun = 1'b0;
	endtask

	task automatic decode_byte(input sfd_in_t b);
		sfd_res_t r;
		logic [15:0] rx_crc;
		if (frame_pos >= FRAME_MAX) begin
			// bytes past the maximum are dropped
			frame_overrun = 1'b1;
		end else begin
			if (frame_pos >= 2) begin
				crc_acc = crc_after_byte(crc_acc, dly[0]);
				if (frame_pos - 2 >= HEADER_BYTES) begin
					r = '0;
					r.out_kind = PH_PAY;
					r.out_last = !b.in_last;
					r.out_byte = dly[0];
					frame_results_due.push_back(r);
				end
			end
			dly[0] = dly[1];
			dly[1] = b.in_byte;
			if (frame_pos == 0) begin
				sync_match = sync_match && (b.in_byte == sync_a);
			end else if (frame_pos == 1) begin
				sync_match = sync_match && (b.in_byte == sync_b);
			end else if (frame_pos == 2) begin
				cap_node = b.in_byte;
			end else if (frame_pos == 3) begin
				cap_type = b.in_byte;
			end else if (frame_pos < HEADER_BYTES) begin
				cap_time[(frame_pos - 4) * 8 +: 8] = b.in_byte;
			end
			frame_pos++;
		end
		if (b.in_last) begin
			r = '0;
			r.out_kind = PH_STAT;
			r.out_last = 1'b1;
			r.node_id = cap_node;
			r.sensor_type = cap_type;
			r.timestamp = cap_time;
			rx_crc = {dly[1], dly[0]};
			if (frame_pos < MIN_FRAME) begin
				r.frame_status = ST_SHORT;
			end else if (frame_overrun) begin
				r.frame_status = ST_LONG;
			end else begin
				r.payload_len = PLEN_W'(frame_pos - MIN_FRAME);
				if (!sync_match) begin
					r.frame_status = ST_SYNC;
				end else if (rx_crc != crc_acc) begin
					r.frame_status = ST_CRC;
				end else begin
					r.frame_status = ST_OK;
				end
			end
			frame_results_due.push_back(r);
			clear_frame_state();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	// size is the payload length for framed kinds and the whole length otherwise
	task automatic queue_frame(input frame_kind_t kind, input int unsigned size);
		logic [7:0] fb [$];
		logic [15:0] c;
		sfd_in_t nxt;
		c = CRC_INIT;
		case (kind) inside
			FR_SHORT, FR_LONG, FR_NOISE: begin
				repeat (size) fb.push_back(8'($urandom));
				if ($urandom_range(0, 1)) begin
					fb[0] = sync_a;
					if (size > 1) begin
						fb[1] = sync_b;
					end
				end
			end
			default: begin
				fb.push_back(sync_a);
				fb.push_back(sync_b);
				repeat (HEADER_BYTES - 2 + size) fb.push_back(8'($urandom));
				if (kind == FR_BAD_SYNC) begin
					fb[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
				end
				foreach (fb[i]) begin
					c = crc_after_byte(c, fb[i]);
				end
				fb.push_back(c[7:0]);
				fb.push_back(c[15:8]);
				if (kind == FR_BAD_CRC || (kind == FR_BAD_SYNC && $urandom_range(0, 1))) begin
					fb[$urandom_range(2, fb.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
				end
			end
		endcase
		foreach (fb[i]) begin
			nxt.in_byte = fb[i];
			nxt.in_last = (i == fb.size() - 1);
			bytes_to_send.push_back(nxt);
			bytes_sent++;
		end
	endtask

	task automatic write_sync(input cfg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == CFG_SYNC_FIRST) begin
			sync_a = val;
		end else begin
			sync_b = val;
		end
	endtask

	task automatic wait_drained();
		while (bytes_taken != bytes_sent || frame_results_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// driver: both handshakes move on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				send_wait = draw_gap(send_run, send_calm);
			end
			if (!push || in_taken) begin
				if (send_wait != 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (bytes_to_send.size() != 0) begin
					item <= bytes_to_send.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
			if (res_taken) begin
				recv_wait = draw_gap(recv_run, recv_calm);
			end
			if (recv_wait != 0) begin
				recv_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// monitor: predicts on each byte transfer, checks each result transfer
	always @(posedge clk) begin
		sfd_res_t due;
		in_taken = 1'b0;
		res_taken = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				in_taken = 1'b1;
				bytes_taken++;
				decode_byte(item);
			end
			if (pop && !empty) begin
				res_taken = 1'b1;
				if (frame_results_due.size() == 0) begin
					$error("unexpected result: kind %0d status %0d byte %0h",
						result.out_kind, result.frame_status, result.out_byte);
					failed = 1'b1;
				end else begin
					due = frame_results_due.pop_front();
					check_field("out_kind", due.out_kind, result.out_kind);
					check_field("out_last", due.out_last, result.out_last);
					check_field("out_byte", due.out_byte, result.out_byte);
					check_field("frame_status", due.frame_status, result.frame_status);
					check_field("node_id", due.node_id, result.node_id);
					check_field("sensor_type", due.sensor_type, result.sensor_type);
					check_field("timestamp", due.timestamp, result.timestamp);
					check_field("payload_len", due.payload_len, result.payload_len);
				end
			end
			if (in_taken || res_taken) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$error("no transfer for %0d cycles, %0d results outstanding",
						idle_cycles, frame_results_due.size());
					$display("tb_sensor_frame_decoder failed");
					$finish;
				end
			end
		end
	end

	initial begin
		int unsigned target;
		int unsigned pick;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames under the reset sync bytes
		queue_frame(FR_SHORT, 1);
		queue_frame(FR_SHORT, MIN_FRAME - 1);
		queue_frame(FR_GOOD, 0);
		queue_frame(FR_GOOD, 1);
		queue_frame(FR_BAD_SYNC, 2);
		queue_frame(FR_BAD_CRC, 0);
		queue_frame(FR_GOOD, FRAME_MAX - MIN_FRAME);
		queue_frame(FR_LONG, FRAME_MAX + 1);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				1: begin
					write_sync(CFG_SYNC_FIRST, 8'h00);
					write_sync(CFG_SYNC_SECOND, 8'hFF);
				end
				2: begin
					write_sync(CFG_SYNC_FIRST, 8'hFF);
					write_sync(CFG_SYNC_SECOND, 8'h00);
				end
				3: begin
					write_sync(CFG_SYNC_FIRST, 8'($urandom));
					write_sync(CFG_SYNC_SECOND, 8'($urandom));
				end
				default: ;
			endcase
			target = bytes_sent + BYTES_PER_PHASE;
			while (bytes_sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					queue_frame(FR_GOOD, ($urandom_range(0, 6) != 0) ? $urandom_range(0, 12)
						: $urandom_range(0, FRAME_MAX - MIN_FRAME));
				end else if (pick < 65) begin
					queue_frame(FR_BAD_CRC, $urandom_range(0, 20));
				end else if (pick < 75) begin
					queue_frame(FR_BAD_SYNC, $urandom_range(0, 20));
				end else if (pick < 83) begin
					queue_frame(FR_SHORT, $urandom_range(1, MIN_FRAME - 1));
				end else if (pick < 90) begin
					queue_frame(FR_LONG, $urandom_range(FRAME_MAX + 1, FRAME_MAX + 8));
				end else if (pick < 95) begin
					queue_frame(FR_NOISE, $urandom_range(1, FRAME_MAX + 8));
				end else begin
					queue_frame(FR_GOOD, FRAME_MAX - MIN_FRAME);
				end
			end
			wait_drained();
		end

		if (failed) begin
			$display("tb_sensor_frame_decoder failed");
		end else begin
			$display("tb_sensor_frame_decoder passed");
		end
		$finish;
	end

endmodule
